// ===== sv/tapq_pkg.sv =====
// Package for the tick alarm priority queue: field widths, request codes and the
// command and status structs between the controller and the datapath.
// Depends on nothing; every other file imports it.
package tapq_pkg;

	localparam int ID_W         = 4;
	localparam int TICK_FIELD_W = 32;
	localparam int TDATA_W      = 40;
	localparam int PAD_W        = TDATA_W - ID_W - TICK_FIELD_W;
	localparam int TUSER_W      = 1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef struct packed {
		logic load;
		logic inc;
		logic remove;
		logic insert;
		logic pop;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_set;
		logic id_ok;
		logic cancel;
		logic head_due;
		logic out_free;
	} ctrl_stat_t;

endpackage

// ===== sv/tapq_ctrl.sv =====
// Controller of the tick alarm priority queue: sequences the capture, removal,
// insertion and expiry steps of each request. Depends on tapq_pkg.
module tapq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  tapq_pkg::ctrl_stat_t stat,
	output tapq_pkg::ctrl_cmd_t  cmd
);
	import tapq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_REMOVE,
		ST_INSERT,
		ST_FIRE
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!stat.is_set) begin
					cmd.inc = 1'b1;
					state_d = ST_FIRE;
				end else if (stat.id_ok) begin
					state_d = ST_REMOVE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = stat.cancel ? ST_IDLE : ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_FIRE: begin
				if (!stat.head_due) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.pop = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

	assign s_tready = ready_q;

endmodule

// ===== sv/tapq_datapath.sv =====
// Datapath of the tick alarm priority queue: tick counter, sorted alarm queue held
// as a row of shifting entries, request capture and output register. Depends on tapq_pkg.
module tapq_datapath #(
	parameter int NUM_ALARMS = 16,
	parameter int TICK_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tapq_pkg::ctrl_cmd_t                 cmd,
	output tapq_pkg::ctrl_stat_t                stat,
	input  logic [tapq_pkg::TDATA_W-1:0]        s_tdata,
	input  logic [tapq_pkg::TUSER_W-1:0]        s_tuser,
	input  logic                                cfg_valid,
	input  logic [tapq_pkg::TICK_FIELD_W-1:0]   cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tapq_pkg::TDATA_W-1:0]        m_tdata,
	output logic                                m_tlast
);
	import tapq_pkg::*;

	localparam int LEN_W = $clog2(NUM_ALARMS + 1);

	logic [ID_W-1:0]       ids_q [NUM_ALARMS];
	logic [TICK_WIDTH-1:0] dls_q [NUM_ALARMS];
	logic [ID_W-1:0]       up_id [NUM_ALARMS];
	logic [TICK_WIDTH-1:0] up_dl [NUM_ALARMS];
	logic [ID_W-1:0]       dn_id [NUM_ALARMS];
	logic [TICK_WIDTH-1:0] dn_dl [NUM_ALARMS];

	logic [LEN_W-1:0]      len_q;
	logic [TICK_WIDTH-1:0] cnt_q;
	logic                  req_set_q;
	logic [ID_W-1:0]       req_id_q;
	logic [TICK_WIDTH-1:0] req_when_q;

	logic                    out_valid_q;
	logic [ID_W-1:0]         out_id_q;
	logic [TICK_FIELD_W-1:0] out_tick_q;
	logic                    out_last_q;

	logic [NUM_ALARMS-1:0] occ, match, hit, le, due;
	logic [NUM_ALARMS:0]   prev_le, due_ext;
	logic                  found, full;

	always_comb begin
		for (int j = 0; j < NUM_ALARMS; j++) begin
			occ[j]   = LEN_W'(j) < len_q;
			match[j] = occ[j] && (ids_q[j] == req_id_q);
			le[j]    = occ[j] && (dls_q[j] <= req_when_q);
			due[j]   = occ[j] && (dls_q[j] <= cnt_q);
		end
		for (int j = 0; j < NUM_ALARMS; j++) begin
			hit[j] = |(match & ({NUM_ALARMS{1'b1}} >> (NUM_ALARMS - 1 - j)));
		end
		prev_le = {le, 1'b1};
		due_ext = {1'b0, due};
		found   = |match;
		full    = (len_q == LEN_W'(NUM_ALARMS));

		up_id[NUM_ALARMS-1] = ids_q[NUM_ALARMS-1];
		up_dl[NUM_ALARMS-1] = dls_q[NUM_ALARMS-1];
		for (int j = 0; j < NUM_ALARMS - 1; j++) begin
			up_id[j] = ids_q[j+1];
			up_dl[j] = dls_q[j+1];
		end
		dn_id[0] = req_id_q;
		dn_dl[0] = req_when_q;
		for (int j = 1; j < NUM_ALARMS; j++) begin
			dn_id[j] = ids_q[j-1];
			dn_dl[j] = dls_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_ALARMS; j++) begin
			if (cmd.remove) begin
				if (hit[j]) begin
					ids_q[j] <= up_id[j];
					dls_q[j] <= up_dl[j];
				end
			end else if (cmd.insert && !full) begin
				if (!le[j]) begin
					ids_q[j] <= prev_le[j] ? req_id_q : dn_id[j];
					dls_q[j] <= prev_le[j] ? req_when_q : dn_dl[j];
				end
			end else if (cmd.pop) begin
				ids_q[j] <= up_id[j];
				dls_q[j] <= up_dl[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_set_q  <= (s_tuser[0] == CMD_SET);
			req_id_q   <= s_tdata[ID_W-1:0];
			req_when_q <= TICK_WIDTH'(s_tdata[ID_W +: TICK_FIELD_W]);
		end
		if (cmd.pop) begin
			out_id_q   <= ids_q[0];
			out_tick_q <= TICK_FIELD_W'(cnt_q);
			out_last_q <= !due_ext[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cnt_q <= TICK_WIDTH'(cfg_data);
				len_q <= '0;
			end else begin
				if (cmd.inc) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (cmd.remove && found) begin
					len_q <= len_q - 1'b1;
				end else if (cmd.insert && !full) begin
					len_q <= len_q + 1'b1;
				end else if (cmd.pop) begin
					len_q <= len_q - 1'b1;
				end
			end
			if (cmd.pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.is_set   = req_set_q;
		stat.id_ok    = int'(req_id_q) < NUM_ALARMS;
		stat.cancel   = (req_when_q == '0);
		stat.head_due = due[0];
		stat.out_free = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_tick_q, out_id_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/tick_alarm_priority_queue.sv =====
// Top level of the tick alarm priority queue: joins the controller and the datapath.
// Depends on tapq_pkg, tapq_ctrl and tapq_datapath.
//
// Requests arrive on the s_ channel. A tick request (tuser low) advances the counter
// and then emits one result on the m_ channel for every alarm whose deadline is at or
// below the new count, earliest first, with tlast on the final one of that tick. A
// set request (tuser high) removes the addressed alarm and, unless the deadline is
// zero, queues it again at the new deadline; it gives no result.
// A set request passes through the dispatch, remove and insert states before the next
// request is accepted; a cancel skips the insert state and an out-of-range id skips
// both. During a tick the queue head is compared and popped once per cycle, so one
// result leaves per cycle while the receiver takes them.
// The first result is loaded into the output register by the pop in the fire state,
// after the dispatch state has advanced the counter. When the receiver stalls, the held
// result stays in the output register and popping pauses until it is taken.
// The cfg_ channel loads the tick counter and empties the queue; it is always ready.
// Reset empties the queue and clears the counter. No clearing pass is needed.
module tick_alarm_priority_queue #(
	parameter int NUM_ALARMS = 16,
	parameter int TICK_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tapq_pkg::TDATA_W-1:0]        s_tdata,  // alarm_id, deadline, zero pad
	input  logic [tapq_pkg::TUSER_W-1:0]        s_tuser,  // cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tapq_pkg::TDATA_W-1:0]        m_tdata,  // fired_alarm, fire_tick, zero pad
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tapq_pkg::TICK_FIELD_W-1:0]   cfg_data
);
	import tapq_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	tapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tapq_datapath #(
		.NUM_ALARMS (NUM_ALARMS),
		.TICK_WIDTH (TICK_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	assign cfg_ready = 1'b1;

	a_pop_only_when_due: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (stat.head_due && stat.out_free))
		else $error("Queue head popped while not due or output busy.");

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.pop))
		else $error("Result shown without a pop.");

	a_no_pop_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.pop || cmd.remove || cmd.insert || cmd.inc))
		else $error("Queue changed while a new request could be accepted.");

	a_set_gives_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == CMD_SET)) |=> ##1 !cmd.pop)
		else $error("Set request caused a pop.");

endmodule

// ===== verif/tapq_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the tick alarm priority queue testbench: keeps its own alarm queue and
// tick counter, predicts every expired alarm and checks the results against it.
// Depends on tapq_pkg for the field widths and request codes.
package tapq_tb_pkg;

	import tapq_pkg::*;

	class alarm_expiry_board;

		typedef struct {
			bit [ID_W-1:0]         id;
			bit [TICK_FIELD_W-1:0] tick;
			bit                    last;
		} fire_t;

		bit [TICK_FIELD_W-1:0] tick_count;
		bit [ID_W-1:0]         armed_ids[16];
		bit [TICK_FIELD_W-1:0] armed_deadlines[16];
		int                    armed_len;
		fire_t                 due_fires[$];
		int                    errors;

		function new();
			tick_count = '0;
			armed_len  = 0;
			errors     = 0;
		endfunction

		function void load_start(bit [TICK_FIELD_W-1:0] value);
			tick_count = value;
			armed_len  = 0;
		endfunction

		function void disarm(bit [ID_W-1:0] id);
			int i;
			for (i = 0; i < armed_len; i++) begin
				if (armed_ids[i] == id) begin
					for (int j = i; j + 1 < armed_len; j++) begin
						armed_ids[j]       = armed_ids[j + 1];
						armed_deadlines[j] = armed_deadlines[j + 1];
					end
					armed_len--;
					return;
				end
			end
		endfunction

		function void arm(bit [ID_W-1:0] id, bit [TICK_FIELD_W-1:0] deadline);
			int pos;
			pos = 0;
			if (armed_len >= 16)
				return;
			while (pos < armed_len && armed_deadlines[pos] <= deadline)
				pos++;
			for (int j = armed_len; j > pos; j--) begin
				armed_ids[j]       = armed_ids[j - 1];
				armed_deadlines[j] = armed_deadlines[j - 1];
			end
			armed_ids[pos]       = id;
			armed_deadlines[pos] = deadline;
			armed_len++;
		endfunction

		function void note_request(logic cmd, bit [ID_W-1:0] id,
				bit [TICK_FIELD_W-1:0] deadline);
			fire_t f;
			int    n;
			n = 0;
			if (cmd == CMD_SET) begin
				disarm(id);
				if (deadline != 0)
					arm(id, deadline);
			end else begin
				tick_count = tick_count + 1'b1;
				while (armed_len > 0 && armed_deadlines[0] <= tick_count) begin
					f.id   = armed_ids[0];
					f.tick = tick_count;
					f.last = 1'b0;
					disarm(f.id);
					due_fires.push_back(f);
					n++;
				end
				if (n > 0)
					due_fires[due_fires.size() - 1].last = 1'b1;
			end
		endfunction

		function void check_fire(bit [ID_W-1:0] id, bit [TICK_FIELD_W-1:0] tick, bit last);
			fire_t want;
			if (due_fires.size() == 0) begin
				$display("%0t: unexpected fired alarm id %0d tick %h last %0d",
					$time, id, tick, last);
				errors++;
				return;
			end
			want = due_fires.pop_front();
			if (id != want.id) begin
				$display("%0t: fired_alarm expected %0d actual %0d", $time, want.id, id);
				errors++;
			end
			if (tick != want.tick) begin
				$display("%0t: fire_tick expected %h actual %h", $time, want.tick, tick);
				errors++;
			end
			if (last != want.last) begin
				$display("%0t: last_fired expected %0d actual %0d", $time, want.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return due_fires.size();
		endfunction

	endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top level of the tick alarm priority queue testbench: clock, reset, request and
// configuration drivers, the result receiver and the end-of-run verdict.
// Depends on tapq_pkg, tapq_tb_pkg and tick_alarm_priority_queue.
module tb_top;

	import tapq_pkg::*;
	import tapq_tb_pkg::*;

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [TDATA_W-1:0]      s_tdata   = '0;
	logic [TUSER_W-1:0]      s_tuser   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [TDATA_W-1:0]      m_tdata;
	logic                    m_tlast;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [TICK_FIELD_W-1:0] cfg_data  = '0;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_left     = 0;

	alarm_expiry_board board = new();

	tick_alarm_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_fire(m_tdata[ID_W-1:0], m_tdata[ID_W+TICK_FIELD_W-1:ID_W], m_tlast);
	end

	task automatic send_req(logic cmd, bit [ID_W-1:0] id, bit [TICK_FIELD_W-1:0] deadline);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{PAD_W{1'b0}}, deadline, id};
		do @(posedge clk); while (!s_tready);
		board.note_request(cmd, id, deadline);
	endtask

	task automatic tick();
		send_req(CMD_TICK, ID_W'($urandom_range(0, 15)), $urandom);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (board.pending() > 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		if (board.pending() > 0) begin
			$display("%0t: %0d expected alarms never fired", $time, board.pending());
			board.errors++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic load_start(bit [TICK_FIELD_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.load_start(value);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_reqs(int count);
		int sel;
		bit [TICK_FIELD_W-1:0] deadline;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 45) begin
				tick();
			end else begin
				sel = $urandom_range(0, 9);
				case (sel)
					0: deadline = '0;
					1: deadline = $urandom;
					2: deadline = board.tick_count;
					default: deadline = board.tick_count + $urandom_range(1, 8);
				endcase
				send_req(CMD_SET, ID_W'($urandom_range(0, 15)), deadline);
			end
			if ($urandom_range(0, 99) < 4)
				drain();
		end
	endtask

	task automatic fill_and_hold();
		for (int id = 0; id < 16; id++)
			send_req(CMD_SET, ID_W'(id), board.tick_count + 1);
		hold_left = 300;
		tick();
		random_reqs(20);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ordering of equal deadlines, re-arming, cancelling and cancelling an absent alarm.
		send_req(CMD_SET, 0, 2);
		send_req(CMD_SET, 15, 1);
		send_req(CMD_SET, 5, 2);
		send_req(CMD_SET, 7, 3);
		send_req(CMD_SET, 7, 0);
		send_req(CMD_SET, 9, 0);
		send_req(CMD_SET, 3, 5);
		send_req(CMD_SET, 3, 2);
		tick();
		tick();
		tick();

		// Counter wrap with the largest deadline.
		load_start(32'hFFFF_FFFD);
		send_req(CMD_SET, 2, 32'hFFFF_FFFF);
		send_req(CMD_SET, 4, 1);
		send_req(CMD_SET, 6, 32'hFFFF_FFFE);
		tick();
		tick();
		tick();
		tick();

		load_start(32'h0000_0000);
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		random_reqs(28);
		fill_and_hold();

		load_start(32'hFFFF_FFFF);
		src_idle_pct  = 72;
		snk_stall_pct = 0;
		random_reqs(28);

		load_start($urandom);
		src_idle_pct  = 0;
		snk_stall_pct = 72;
		random_reqs(28);

		load_start(32'hFFFF_FFF8);
		src_idle_pct  = 11;
		snk_stall_pct = 11;
		random_reqs(28);

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tapq_pkg.sv
sv/tapq_ctrl.sv
sv/tapq_datapath.sv
sv/tick_alarm_priority_queue.sv
verif/tapq_tb_pkg.sv
verif/tb_top.sv
